// ===== rtl/core/mre_pkg.sv =====
package mre_pkg;

    // Largest read byte count accepted in a reply
    localparam int MAX_DATA = 8;

    // Counter wide enough for the write echo (6), the data count and the 8 frame bytes
    localparam int CNT_MAX = (MAX_DATA + 1 > 8) ? MAX_DATA + 1 : 8;
    localparam int CNT_W   = $clog2(CNT_MAX);
    // Index into the read data store
    localparam int DS_AW   = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FC_READ  = 8'h03;
    localparam logic [7:0]  FC_WRITE = 8'h06;

    localparam logic [7:0]  SLAVE_ADDR_RST = 8'h20;
    localparam logic [15:0] TIMEOUT_RST    = 16'd800;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'b1;

    // Number of request bytes ahead of the CRC, and the write echo length
    localparam logic [CNT_W-1:0] TX_CRC_POS   = CNT_W'(6);
    localparam logic [CNT_W-1:0] TX_LAST_POS  = CNT_W'(7);
    localparam logic [CNT_W-1:0] WR_ECHO_LEN  = CNT_W'(6);
    localparam logic [CNT_W-1:0] HDR_CNT_POS  = CNT_W'(2);
    localparam logic [7:0]       MAX_DATA_B   = 8'(MAX_DATA);

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_RXBYTE = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_BAD_HDR = 3'd2,
        ST_COUNT   = 3'd3,
        ST_CRC     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HDR   = 3'd1,
        PH_DATA  = 3'd2,
        PH_CRCLO = 3'd3,
        PH_CRCHI = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        BK_NONE   = 2'd0,
        BK_TX     = 2'd1,
        BK_RESULT = 2'd2
    } t_bkind;

    typedef struct packed {
        t_action     action;
        logic [15:0] reg_addr;
        logic [15:0] word;
        logic [7:0]  rx_byte;
    } t_req;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        t_status     status;
        logic        last;
    } t_res;

    // Work handed from the controller to the result sequencer
    typedef struct packed {
        t_bkind           kind;
        logic [7:0]       slave_addr;
        logic [7:0]       func;
        logic [15:0]      reg_addr;
        logic [15:0]      word;
        logic [CNT_W-1:0] n_data;
        t_status          status;
    } t_burst;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/mre_ctrl.sv =====
module mre_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  mre_pkg::t_req            i_req,
    input  logic [7:0]               i_slave_addr,
    input  logic [15:0]              i_timeout,
    input  logic [mre_pkg::DS_AW-1:0] i_rd_idx,
    output logic [7:0]               o_rd_data,
    output mre_pkg::t_burst          o_burst
);

    mre_pkg::t_phase                r_phase, n_phase;
    logic                           r_pend_wr, n_pend_wr;
    logic [mre_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic [15:0]                    r_crc, n_crc;
    logic [mre_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [7:0]                     r_crc_lo, n_crc_lo;
    logic                           r_hdr_bad, n_hdr_bad;
    logic [15:0]                    r_wait, n_wait;
    logic [7:0]                     r_store [mre_pkg::MAX_DATA];
    logic [7:0]                     r_rd_data;

    logic                           is_send;
    logic                           is_byte;
    logic                           is_tick;
    logic [7:0]                     rx;
    logic [15:0]                    crc_rx;
    logic [7:0]                     exp_func;
    logic [15:0]                    wait_inc;
    logic                           timed_out;
    logic                           hdr_bad_upd;
    logic                           cnt_big;
    logic                           crc_ok;
    logic [mre_pkg::CNT_W-1:0]      idx_inc;
    logic                           store_we;

    assign rx       = i_req.rx_byte;
    assign is_send  = (i_req.action == mre_pkg::ACT_READ) || (i_req.action == mre_pkg::ACT_WRITE);
    assign is_byte  = (i_req.action == mre_pkg::ACT_RXBYTE);
    assign is_tick  = (i_req.action == mre_pkg::ACT_TICK);
    assign crc_rx   = mre_pkg::crc16_byte(r_crc, rx);
    assign exp_func = r_pend_wr ? mre_pkg::FC_WRITE : mre_pkg::FC_READ;
    assign wait_inc = (r_wait == 16'hFFFF) ? r_wait : r_wait + 16'd1;
    assign timed_out = (wait_inc >= i_timeout);
    assign hdr_bad_upd = r_hdr_bad
                       | ((r_idx == '0) && (rx != i_slave_addr))
                       | ((r_idx == mre_pkg::CNT_W'(1)) && (rx != exp_func));
    assign cnt_big  = (rx > mre_pkg::MAX_DATA_B);
    assign crc_ok   = ({rx, r_crc_lo} == r_crc);
    assign idx_inc  = r_idx + mre_pkg::CNT_W'(1);
    assign store_we = i_fire && is_byte && (r_phase == mre_pkg::PH_DATA);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            priority if (is_send) begin
                n_phase = mre_pkg::PH_HDR;
            end else if (r_phase == mre_pkg::PH_IDLE) begin
                n_phase = mre_pkg::PH_IDLE;
            end else if (is_tick) begin
                if (timed_out) begin
                    n_phase = mre_pkg::PH_IDLE;
                end
            end else begin
                unique case (r_phase)
                    mre_pkg::PH_HDR: begin
                        if (r_pend_wr) begin
                            if (idx_inc >= mre_pkg::WR_ECHO_LEN) begin
                                n_phase = mre_pkg::PH_CRCLO;
                            end
                        end else if (r_idx >= mre_pkg::HDR_CNT_POS) begin
                            if (hdr_bad_upd || cnt_big) begin
                                n_phase = mre_pkg::PH_IDLE;
                            end else if (rx == 8'h00) begin
                                n_phase = mre_pkg::PH_CRCLO;
                            end else begin
                                n_phase = mre_pkg::PH_DATA;
                            end
                        end
                    end
                    mre_pkg::PH_DATA: begin
                        if (idx_inc >= r_cnt) begin
                            n_phase = mre_pkg::PH_CRCLO;
                        end
                    end
                    mre_pkg::PH_CRCLO: n_phase = mre_pkg::PH_CRCHI;
                    mre_pkg::PH_CRCHI: n_phase = mre_pkg::PH_IDLE;
                    default:           n_phase = mre_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // Datapath and result burst
    always_comb begin
        n_pend_wr = r_pend_wr;
        n_idx     = r_idx;
        n_crc     = r_crc;
        n_cnt     = r_cnt;
        n_crc_lo  = r_crc_lo;
        n_hdr_bad = r_hdr_bad;
        n_wait    = r_wait;
        o_burst            = '0;
        o_burst.kind       = mre_pkg::BK_NONE;
        o_burst.status     = mre_pkg::ST_OK;
        o_burst.slave_addr = i_slave_addr;
        o_burst.reg_addr   = i_req.reg_addr;
        o_burst.word       = i_req.word;
        o_burst.func       = (i_req.action == mre_pkg::ACT_WRITE) ? mre_pkg::FC_WRITE
                                                                  : mre_pkg::FC_READ;
        if (i_fire) begin
            priority if (is_send) begin
                n_pend_wr    = (i_req.action == mre_pkg::ACT_WRITE);
                n_idx        = '0;
                n_crc        = mre_pkg::CRC_INIT;
                n_cnt        = '0;
                n_crc_lo     = '0;
                n_hdr_bad    = 1'b0;
                n_wait       = '0;
                o_burst.kind = mre_pkg::BK_TX;
            end else if (r_phase == mre_pkg::PH_IDLE) begin
                // stray byte or tick: dropped
            end else if (is_tick) begin
                n_wait = wait_inc;
                if (timed_out) begin
                    o_burst.kind   = mre_pkg::BK_RESULT;
                    o_burst.status = mre_pkg::ST_TIMEOUT;
                end
            end else begin
                n_wait = '0;
                unique case (r_phase)
                    mre_pkg::PH_HDR: begin
                        n_crc     = crc_rx;
                        n_hdr_bad = hdr_bad_upd;
                        if (r_pend_wr) begin
                            n_idx = idx_inc;
                        end else if (r_idx >= mre_pkg::HDR_CNT_POS) begin
                            if (hdr_bad_upd) begin
                                o_burst.kind   = mre_pkg::BK_RESULT;
                                o_burst.status = mre_pkg::ST_BAD_HDR;
                            end else if (cnt_big) begin
                                o_burst.kind   = mre_pkg::BK_RESULT;
                                o_burst.status = mre_pkg::ST_COUNT;
                            end else begin
                                n_cnt = rx[mre_pkg::CNT_W-1:0];
                                n_idx = '0;
                            end
                        end else begin
                            n_idx = idx_inc;
                        end
                    end
                    mre_pkg::PH_DATA: begin
                        n_crc = crc_rx;
                        n_idx = idx_inc;
                    end
                    mre_pkg::PH_CRCLO: begin
                        n_crc_lo = rx;
                    end
                    mre_pkg::PH_CRCHI: begin
                        o_burst.kind = mre_pkg::BK_RESULT;
                        if (!crc_ok) begin
                            o_burst.status = mre_pkg::ST_CRC;
                        end else if (r_hdr_bad) begin
                            o_burst.status = mre_pkg::ST_BAD_HDR;
                        end else begin
                            o_burst.status = mre_pkg::ST_OK;
                            o_burst.n_data = r_pend_wr ? '0 : r_cnt;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mre_pkg::PH_IDLE;
            r_pend_wr <= 1'b0;
            r_idx     <= '0;
            r_crc     <= mre_pkg::CRC_INIT;
            r_cnt     <= '0;
            r_crc_lo  <= '0;
            r_hdr_bad <= 1'b0;
            r_wait    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pend_wr <= n_pend_wr;
            r_idx     <= n_idx;
            r_crc     <= n_crc;
            r_cnt     <= n_cnt;
            r_crc_lo  <= n_crc_lo;
            r_hdr_bad <= n_hdr_bad;
            r_wait    <= n_wait;
        end
    end

    // Read data held until the CRC has been checked; read port registered,
    // addressed with the sequencer's next position
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_idx[mre_pkg::DS_AW-1:0]] <= rx;
        end
        r_rd_data <= r_store[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/mre_emit.sv =====
module mre_emit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  mre_pkg::t_burst           i_burst,
    output logic                      o_load_ok,
    output logic [mre_pkg::DS_AW-1:0] o_rd_idx,
    input  logic [7:0]                i_rd_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output mre_pkg::t_res             o_res
);

    logic                      r_busy;
    mre_pkg::t_burst           r_desc;
    logic [mre_pkg::CNT_W-1:0] r_pos, n_pos;
    logic [15:0]               r_txcrc;

    logic                      is_tx;
    logic                      in_data;
    logic                      last_item;
    logic                      take;
    logic [7:0]                tx_byte;

    assign is_tx     = (r_desc.kind == mre_pkg::BK_TX);
    assign in_data   = (r_pos < r_desc.n_data);
    assign last_item = is_tx ? (r_pos == mre_pkg::TX_LAST_POS) : (r_pos == r_desc.n_data);
    assign take      = r_busy && i_ready;
    assign o_load_ok = !r_busy || (i_ready && last_item);
    assign o_valid   = r_busy;
    // the registered store read is addressed with the position held next, to line up with r_pos
    assign o_rd_idx  = n_pos[mre_pkg::DS_AW-1:0];

    always_comb begin
        n_pos = r_pos;
        if (i_load) begin
            n_pos = '0;
        end else if (take && !last_item) begin
            n_pos = r_pos + mre_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        unique case (r_pos[2:0])
            3'd0:    tx_byte = r_desc.slave_addr;
            3'd1:    tx_byte = r_desc.func;
            3'd2:    tx_byte = r_desc.reg_addr[15:8];
            3'd3:    tx_byte = r_desc.reg_addr[7:0];
            3'd4:    tx_byte = r_desc.word[15:8];
            3'd5:    tx_byte = r_desc.word[7:0];
            3'd6:    tx_byte = r_txcrc[7:0];
            default: tx_byte = r_txcrc[15:8];
        endcase
    end

    always_comb begin
        o_res.status = mre_pkg::ST_OK;
        o_res.last   = 1'b0;
        if (is_tx) begin
            o_res.kind     = mre_pkg::KIND_TX;
            o_res.out_byte = tx_byte;
        end else if (in_data) begin
            o_res.kind     = mre_pkg::KIND_DATA;
            o_res.out_byte = i_rd_data;
        end else begin
            o_res.kind     = mre_pkg::KIND_STATUS;
            o_res.out_byte = 8'h00;
            o_res.status   = r_desc.status;
            o_res.last     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else begin
            r_pos <= n_pos;
            if (i_load) begin
                r_busy <= (i_burst.kind != mre_pkg::BK_NONE);
            end else if (take && last_item) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Request CRC built one byte per cycle while the output is ready, as the header goes out
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc  <= i_burst;
            r_txcrc <= mre_pkg::CRC_INIT;
        end else if (take && is_tx && (r_pos < mre_pkg::TX_CRC_POS)) begin
            r_txcrc <= mre_pkg::crc16_byte(r_txcrc, tx_byte);
        end
    end

endmodule

// ===== rtl/core/modbus_rtu_master_engine.sv =====
// Modbus RTU master engine for a single slave. A read (0x03) or write (0x06) request
// item produces the 8 request bytes, CRC-16 (0xA001, seed 0xFFFF) appended low byte
// first; received-byte and tick items then check the reply and each run closes with one
// status result (ok, timeout, bad address/function, count too large, CRC mismatch).
// Read data bytes come out only after the reply CRC has matched. A request item is held
// in an input register until the sequencer can take it; its results start the cycle
// after and leave at one per cycle while the output is ready. Items giving no result
// (most received bytes and ticks) are taken every cycle while the sequencer is idle.
// An item giving several results (8 for a send, up to MAX_DATA+1 at the end of a read)
// holds the sequencer until its last result goes, when the next item is taken. Config
// writes are taken every cycle and should be made only while no run is in progress.
module modbus_rtu_master_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mre_pkg::t_req                 i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mre_pkg::t_res                 o_out_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);

    logic                      r_in_vld;
    mre_pkg::t_req             r_in;
    logic [7:0]                r_slave_addr;
    logic [15:0]               r_timeout;

    logic                      load_ok;
    logic                      fire;
    mre_pkg::t_burst           burst;
    logic [mre_pkg::DS_AW-1:0] rd_idx;
    logic [7:0]                rd_data;

    // request moves on once the sequencer can take its results
    assign fire        = r_in_vld && load_ok;
    assign o_in_ready  = !r_in_vld || load_ok;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_req;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= mre_pkg::SLAVE_ADDR_RST;
            r_timeout    <= mre_pkg::TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mre_pkg::CFG_SLAVE_ADDR) begin
                r_slave_addr <= i_cfg_data[7:0];
            end else if (i_cfg_index == mre_pkg::CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // reply checker and run state
    mre_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_req        (r_in),
        .i_slave_addr (r_slave_addr),
        .i_timeout    (r_timeout),
        .i_rd_idx     (rd_idx),
        .o_rd_data    (rd_data),
        .o_burst      (burst)
    );

    // result sequencer: request bytes, data bytes, status
    mre_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (fire),
        .i_burst   (burst),
        .o_load_ok (load_ok),
        .o_rd_idx  (rd_idx),
        .i_rd_data (rd_data),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_res     (o_out_res)
    );

endmodule
